### src/line_buffer_edit_engine_macros.svh
// ----------------------------------------------------------------------------
// Line buffer edit engine assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINE_BUFFER_EDIT_ENGINE_MACROS_SVH
`define LINE_BUFFER_EDIT_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LBE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line buffer edit engine check failed");

// next-cycle implication, disabled while reset is held
`define LBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line buffer edit engine check failed");

`endif

### src/lbe_pkg.sv
// ----------------------------------------------------------------------------
// lbe_pkg
// Types, codes and defaults of the line buffer edit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbe_pkg;

    localparam int LINE_SLOTS_DEF = 64;
    localparam int LINE_BYTES_DEF = 128;
    localparam logic [7:0] PAGE_ROWS_RESET = 8'd24;

    typedef enum logic [3:0] {
        OP_INSERT = 4'd0,
        OP_SPLIT  = 4'd1,
        OP_BKSP   = 4'd2,
        OP_DEL    = 4'd3,
        OP_LEFT   = 4'd4,
        OP_RIGHT  = 4'd5,
        OP_UP     = 4'd6,
        OP_DOWN   = 4'd7,
        OP_HOME   = 4'd8,
        OP_END    = 4'd9,
        OP_PGUP   = 4'd10,
        OP_PGDN   = 4'd11,
        OP_READ   = 4'd12,
        OP_SAVED  = 4'd13
    } lbe_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_EXEC,
        ST_COPY,
        ST_MVRD,
        ST_MVLEN,
        ST_SPTAIL,
        ST_SPEND,
        ST_PUT,
        ST_JEND,
        ST_RDTXT,
        ST_FIN
    } lbe_state_t;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] character;
        logic [5:0] read_line;
        logic [6:0] read_col;
    } lbe_in_t;

    typedef struct packed {
        logic [5:0] cursor_line;
        logic [6:0] cursor_col;
        logic [6:0] line_count;
        logic [5:0] view_top;
        logic       modified;
        logic       applied;
        logic [7:0] read_data;
    } lbe_out_t;

endpackage

### src/line_buffer_edit_engine.sv
// ----------------------------------------------------------------------------
// line_buffer_edit_engine
// Line-array text buffer with a cursor, edited one operation per transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    lbe_in_t  (operation, character, read pos)
// m_        out        m_valid / m_ready    lbe_out_t (cursor, counts, flags, read byte)
// cfg_      in         cfg_wr_en            cfg_wr_data = page_rows
//
// One transaction at a time. Insert, backspace and delete shift the rest of the
// line behind the cursor one byte per cycle, through the separate read and write
// ports of the text memory. Split moves every line below the cursor down one slot
// and join moves every line below the two joined lines up one slot, byte by byte.
// Reset is synchronous and leaves one empty line; no clearing pass is needed.
// A result waiting on m_ready does not block the next s_ transaction until
// that one finishes and finds the output register still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_buffer_edit_engine #(
    parameter int LINE_SLOTS = lbe_pkg::LINE_SLOTS_DEF,
    parameter int LINE_BYTES = lbe_pkg::LINE_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lbe_pkg::lbe_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lbe_pkg::lbe_out_t m_data,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data
);
    import lbe_pkg::*;

    localparam int RW  = $clog2(LINE_SLOTS);          // row index
    localparam int CW  = $clog2(LINE_BYTES);          // column / length
    localparam int NW  = $clog2(LINE_SLOTS + 1);      // line count
    localparam int AW  = RW + CW;                     // text address {row, col}
    localparam int TD  = LINE_SLOTS * (1 << CW);
    localparam int SW  = ((NW > 8) ? NW : 8) + 1;     // row plus page sums
    localparam int LXW = (NW > 6) ? NW : 6;
    localparam int CXW = (CW > 7) ? CW : 7;

    // text and line length storage
    logic [7:0]    txt_mem [TD];
    logic [CW-1:0] len_mem [LINE_SLOTS];

    logic [LINE_SLOTS-1:0] len_vld_reg;
    logic [CW-1:0] len_rd_reg;
    logic          len_rvld_reg;
    logic [CW-1:0] len_rd;
    logic [7:0]    txt_rd_reg;

    logic          len_we;
    logic [RW-1:0] len_waddr, len_raddr;
    logic [CW-1:0] len_wdata;
    logic          put_we;
    logic [AW-1:0] txt_raddr;
    logic          txt_we;
    logic [AW-1:0] txt_waddr;
    logic [7:0]    txt_wdata;

    // control state
    lbe_state_t state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [NW-1:0] lines_reg, lines_next;
    logic [RW-1:0] top_reg, top_next;
    logic          mod_reg, mod_next;
    logic [7:0]    page_rows_reg;
    logic          m_valid_reg, m_valid_next;
    logic          wr_pend_reg, wr_pend_next;

    // per-transaction payload
    lbe_op_t       op_reg;
    logic [7:0]    ch_reg;
    logic [5:0]    rl_reg;
    logic [6:0]    rc_reg;
    logic [RW-1:0] old_row_reg;
    logic [CW-1:0] old_col_reg;
    logic [CW-1:0] len_cur_reg, len_cur_next;
    logic [RW-1:0] aux_row_reg, aux_row_next;
    logic          chg_reg, chg_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [7:0]    rdata_reg, rdata_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;

    // byte copy engine
    logic [AW-1:0] cp_src_reg, cp_src_next, cp_dst_reg, cp_dst_next;
    logic [CW-1:0] cp_cnt_reg, cp_cnt_next;
    logic          cp_dec_reg, cp_dec_next;
    lbe_state_t    cp_ret_reg, cp_ret_next;

    // line move loop
    logic [RW-1:0] mv_dst_reg, mv_dst_next;
    logic [NW-1:0] mv_cnt_reg, mv_cnt_next;
    logic          mv_up_reg, mv_up_next;
    lbe_state_t    mv_ret_reg, mv_ret_next;
    logic [RW-1:0] mv_src;

    lbe_out_t      out_reg, out_next;

    // derived conditions
    logic [7:0]    rows;
    logic          accept, out_free;
    logic          row_has_next, row_has_prev;
    logic          ins_ok, split_ok, bs_char, del_char, join_bs, join_del, join_ok;
    logic [CW-1:0] ja, jb, clamp_col;
    logic [CW:0]   jsum;
    logic [RW-1:0] ju, ju1;
    logic [SW-1:0] pg_sum, aux_wide;

    assign rows     = (page_rows_reg == 8'd0) ? 8'd1 : page_rows_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    assign len_rd       = len_rvld_reg ? len_rd_reg : '0;
    assign row_has_prev = (row_reg != '0);
    assign row_has_next = (NW'(row_reg) + NW'(1)) < lines_reg;

    assign ins_ok   = (ch_reg != 8'd0) && (CXW'(len_cur_reg) < CXW'(LINE_BYTES - 1));
    assign split_ok = (SW'(lines_reg) < SW'(LINE_SLOTS));
    assign bs_char  = (col_reg != '0);
    assign del_char = (col_reg < len_cur_reg);
    assign join_bs  = (op_reg == OP_BKSP) && !bs_char && row_has_prev;
    assign join_del = (op_reg == OP_DEL) && !del_char && row_has_next;
    assign ja       = join_bs ? len_rd : len_cur_reg;
    assign jb       = join_bs ? len_cur_reg : len_rd;
    assign jsum     = (CW+1)'(ja) + (CW+1)'(jb);
    assign join_ok  = (join_bs || join_del) && (SW'(jsum) < SW'(LINE_BYTES));
    assign ju       = join_bs ? (row_reg - RW'(1)) : row_reg;
    assign ju1      = ju + RW'(1);
    assign clamp_col = (col_reg > len_rd) ? len_rd : col_reg;
    assign mv_src   = mv_up_reg ? (mv_dst_reg + RW'(1)) : (mv_dst_reg - RW'(1));
    assign pg_sum   = SW'(row_reg) + SW'(rows);

    // second length read: the row the operation looks at besides the cursor row
    always_comb begin
        unique case (op_reg)
            OP_PGUP: begin
                aux_wide = (SW'(rows) > SW'(row_reg)) ? '0 : (SW'(row_reg) - SW'(rows));
            end
            OP_PGDN: begin
                aux_wide = (pg_sum >= SW'(lines_reg)) ? (SW'(lines_reg) - SW'(1)) : pg_sum;
            end
            OP_LEFT, OP_UP, OP_BKSP: begin
                aux_wide = SW'(row_reg - RW'(1));
            end
            OP_RIGHT, OP_DOWN, OP_DEL: begin
                aux_wide = SW'(row_reg + RW'(1));
            end
            OP_READ: begin
                aux_wide = SW'(rl_reg);
            end
            default: begin
                aux_wide = SW'(row_reg);
            end
        endcase
    end
    assign aux_row_next = aux_wide[RW-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LEN;
            ST_LEN:    state_next = ST_EXEC;
            ST_EXEC: begin
                unique case (op_reg)
                    OP_INSERT: state_next = ins_ok ? ST_COPY : ST_FIN;
                    OP_SPLIT:  state_next = split_ok ? ST_MVRD : ST_FIN;
                    OP_BKSP:   state_next = (bs_char || join_ok) ? ST_COPY : ST_FIN;
                    OP_DEL:    state_next = (del_char || join_ok) ? ST_COPY : ST_FIN;
                    OP_READ:   state_next = ST_RDTXT;
                    default:   state_next = ST_FIN;
                endcase
            end
            ST_COPY:   if (cp_cnt_reg == '0) state_next = cp_ret_reg;
            ST_MVRD:   state_next = (mv_cnt_reg == '0) ? mv_ret_reg : ST_MVLEN;
            ST_MVLEN:  state_next = ST_COPY;
            ST_SPTAIL: state_next = ST_COPY;
            ST_SPEND:  state_next = ST_FIN;
            ST_PUT:    state_next = ST_FIN;
            ST_JEND:   state_next = ST_FIN;
            ST_RDTXT:  state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        row_next     = row_reg;
        col_next     = col_reg;
        lines_next   = lines_reg;
        top_next     = top_reg;
        mod_next     = mod_reg;
        len_cur_next = len_cur_reg;
        chg_next     = chg_reg;
        rd_ok_next   = rd_ok_reg;
        rdata_next   = rdata_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        cp_src_next  = cp_src_reg;
        cp_dst_next  = cp_dst_reg;
        cp_cnt_next  = cp_cnt_reg;
        cp_dec_next  = cp_dec_reg;
        cp_ret_next  = cp_ret_reg;
        mv_dst_next  = mv_dst_reg;
        mv_cnt_next  = mv_cnt_reg;
        mv_up_next   = mv_up_reg;
        mv_ret_next  = mv_ret_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        len_we       = 1'b0;
        len_waddr    = row_reg;
        len_wdata    = '0;
        len_raddr    = row_reg;
        txt_raddr    = cp_src_reg;
        put_we       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                chg_next   = 1'b0;
                rdata_next = 8'd0;
            end
            ST_LEN: begin
                len_cur_next = len_rd;
                len_raddr    = aux_row_next;
            end
            ST_EXEC: begin
                unique case (op_reg)
                    OP_INSERT: begin
                        // open a gap at the cursor, last byte first
                        cp_src_next = {row_reg, len_cur_reg - CW'(1)};
                        cp_dst_next = {row_reg, len_cur_reg};
                        cp_cnt_next = len_cur_reg - col_reg;
                        cp_dec_next = 1'b1;
                        cp_ret_next = ST_PUT;
                    end
                    OP_SPLIT: begin
                        mv_dst_next = lines_reg[RW-1:0];
                        mv_cnt_next = lines_reg - NW'(row_reg) - NW'(1);
                        mv_up_next  = 1'b0;
                        mv_ret_next = ST_SPTAIL;
                    end
                    OP_BKSP, OP_DEL: begin
                        if ((op_reg == OP_BKSP) && bs_char) begin
                            cp_src_next = {row_reg, col_reg};
                            cp_dst_next = {row_reg, col_reg - CW'(1)};
                            cp_cnt_next = len_cur_reg - col_reg;
                            cp_dec_next = 1'b0;
                            cp_ret_next = ST_FIN;
                            len_we      = 1'b1;
                            len_wdata   = len_cur_reg - CW'(1);
                            col_next    = col_reg - CW'(1);
                            chg_next    = 1'b1;
                        end else if ((op_reg == OP_DEL) && del_char) begin
                            cp_src_next = {row_reg, col_reg + CW'(1)};
                            cp_dst_next = {row_reg, col_reg};
                            cp_cnt_next = len_cur_reg - col_reg - CW'(1);
                            cp_dec_next = 1'b0;
                            cp_ret_next = ST_FIN;
                            len_we      = 1'b1;
                            len_wdata   = len_cur_reg - CW'(1);
                            chg_next    = 1'b1;
                        end else if (join_ok) begin
                            // append the lower line, then pull the rest up one slot
                            len_we      = 1'b1;
                            len_waddr   = ju;
                            len_wdata   = jsum[CW-1:0];
                            cp_src_next = {ju1, CW'(0)};
                            cp_dst_next = {ju, ja};
                            cp_cnt_next = jb;
                            cp_dec_next = 1'b0;
                            cp_ret_next = ST_MVRD;
                            mv_dst_next = ju1;
                            mv_cnt_next = lines_reg - NW'(ju) - NW'(2);
                            mv_up_next  = 1'b1;
                            mv_ret_next = ST_JEND;
                            row_next    = ju;
                            col_next    = ja;
                        end
                    end
                    OP_LEFT: begin
                        if (col_reg != '0) begin
                            col_next = col_reg - CW'(1);
                        end else if (row_has_prev) begin
                            row_next = row_reg - RW'(1);
                            col_next = len_rd;
                        end
                    end
                    OP_RIGHT: begin
                        if (col_reg < len_cur_reg) begin
                            col_next = col_reg + CW'(1);
                        end else if (row_has_next) begin
                            row_next = row_reg + RW'(1);
                            col_next = '0;
                        end
                    end
                    OP_UP: begin
                        if (row_has_prev) begin
                            row_next = row_reg - RW'(1);
                            col_next = clamp_col;
                        end
                    end
                    OP_DOWN: begin
                        if (row_has_next) begin
                            row_next = row_reg + RW'(1);
                            col_next = clamp_col;
                        end
                    end
                    OP_HOME: col_next = '0;
                    OP_END:  col_next = len_cur_reg;
                    OP_PGUP, OP_PGDN: begin
                        row_next = aux_row_reg;
                        col_next = clamp_col;
                    end
                    OP_READ: begin
                        txt_raddr  = {aux_row_reg, CW'(rc_reg)};
                        rd_ok_next = (LXW'(rl_reg) < LXW'(lines_reg))
                                  && (CXW'(rc_reg) < CXW'(len_rd));
                    end
                    OP_SAVED: mod_next = 1'b0;
                    default: begin
                    end
                endcase
            end
            ST_COPY: begin
                // read one byte, write it back in the next cycle
                if (cp_cnt_reg != '0) begin
                    txt_raddr    = cp_src_reg;
                    wr_pend_next = 1'b1;
                    wr_addr_next = cp_dst_reg;
                    cp_cnt_next  = cp_cnt_reg - CW'(1);
                    cp_src_next  = cp_dec_reg ? cp_src_reg - AW'(1) : cp_src_reg + AW'(1);
                    cp_dst_next  = cp_dec_reg ? cp_dst_reg - AW'(1) : cp_dst_reg + AW'(1);
                end
            end
            ST_MVRD: begin
                len_raddr = mv_src;
            end
            ST_MVLEN: begin
                len_we      = 1'b1;
                len_waddr   = mv_dst_reg;
                len_wdata   = len_rd;
                cp_src_next = {mv_src, CW'(0)};
                cp_dst_next = {mv_dst_reg, CW'(0)};
                cp_cnt_next = len_rd;
                cp_dec_next = 1'b0;
                cp_ret_next = ST_MVRD;
                mv_dst_next = mv_up_reg ? (mv_dst_reg + RW'(1)) : (mv_dst_reg - RW'(1));
                mv_cnt_next = mv_cnt_reg - NW'(1);
            end
            ST_SPTAIL: begin
                len_we      = 1'b1;
                len_waddr   = row_reg + RW'(1);
                len_wdata   = len_cur_reg - col_reg;
                cp_src_next = {row_reg, col_reg};
                cp_dst_next = {row_reg + RW'(1), CW'(0)};
                cp_cnt_next = len_cur_reg - col_reg;
                cp_dec_next = 1'b0;
                cp_ret_next = ST_SPEND;
            end
            ST_SPEND: begin
                len_we     = 1'b1;
                len_wdata  = col_reg;
                lines_next = lines_reg + NW'(1);
                row_next   = row_reg + RW'(1);
                col_next   = '0;
                chg_next   = 1'b1;
            end
            ST_PUT: begin
                put_we    = 1'b1;
                len_we    = 1'b1;
                len_wdata = len_cur_reg + CW'(1);
                col_next  = col_reg + CW'(1);
                chg_next  = 1'b1;
            end
            ST_JEND: begin
                // drop the vacated last line
                lines_next = lines_reg - NW'(1);
                len_we     = 1'b1;
                len_waddr  = RW'(lines_reg - NW'(1));
                len_wdata  = '0;
                chg_next   = 1'b1;
            end
            ST_RDTXT: begin
                rdata_next = rd_ok_reg ? txt_rd_reg : 8'd0;
            end
            ST_FIN: begin
                if (out_free) begin
                    // view follows the cursor
                    if (row_reg < top_reg) begin
                        top_next = row_reg;
                    end else if (SW'(row_reg) >= (SW'(top_reg) + SW'(rows))) begin
                        top_next = RW'(SW'(row_reg) - SW'(rows) + SW'(1));
                    end
                    mod_next             = mod_reg | chg_reg;
                    m_valid_next         = 1'b1;
                    out_next.cursor_line = 6'(row_reg);
                    out_next.cursor_col  = 7'(col_reg);
                    out_next.line_count  = 7'(lines_reg);
                    out_next.view_top    = 6'(top_next);
                    out_next.modified    = mod_reg | chg_reg;
                    out_next.applied     = chg_reg || (row_reg != old_row_reg)
                                        || (col_reg != old_col_reg);
                    out_next.read_data   = rdata_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign txt_we    = wr_pend_reg || put_we;
    assign txt_waddr = wr_pend_reg ? wr_addr_reg : {row_reg, col_reg};
    assign txt_wdata = wr_pend_reg ? txt_rd_reg : ch_reg;

    // memories
    always_ff @(posedge aclk) begin
        if (txt_we) begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        txt_rd_reg <= txt_mem[txt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rd_reg   <= len_mem[len_raddr];
        len_rvld_reg <= len_vld_reg[len_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            lines_reg     <= NW'(1);
            top_reg       <= '0;
            mod_reg       <= 1'b0;
            page_rows_reg <= PAGE_ROWS_RESET;
            m_valid_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            len_vld_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            lines_reg   <= lines_next;
            top_reg     <= top_next;
            mod_reg     <= mod_next;
            m_valid_reg <= m_valid_next;
            wr_pend_reg <= wr_pend_next;
            if (cfg_wr_en) begin
                page_rows_reg <= cfg_wr_data;
            end
            if (len_we) begin
                len_vld_reg[len_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= lbe_op_t'(s_data.operation);
            ch_reg      <= s_data.character;
            rl_reg      <= s_data.read_line;
            rc_reg      <= s_data.read_col;
            old_row_reg <= row_reg;
            old_col_reg <= col_reg;
        end
        len_cur_reg <= len_cur_next;
        aux_row_reg <= (state_reg == ST_LEN) ? aux_row_next : aux_row_reg;
        chg_reg     <= chg_next;
        rd_ok_reg   <= rd_ok_next;
        rdata_reg   <= rdata_next;
        wr_addr_reg <= wr_addr_next;
        cp_src_reg  <= cp_src_next;
        cp_dst_reg  <= cp_dst_next;
        cp_cnt_reg  <= cp_cnt_next;
        cp_dec_reg  <= cp_dec_next;
        cp_ret_reg  <= cp_ret_next;
        mv_dst_reg  <= mv_dst_next;
        mv_cnt_reg  <= mv_cnt_next;
        mv_up_reg   <= mv_up_next;
        mv_ret_reg  <= mv_ret_next;
        out_reg     <= out_next;
    end

endmodule

### src/lbe_checker.sv
// ----------------------------------------------------------------------------
// lbe_checker
// Port-level checks of the line buffer edit engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_buffer_edit_engine_macros.svh"

module lbe_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input lbe_pkg::lbe_out_t m_data
);
    import lbe_pkg::*;

    // a stalled result holds
    `LBE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // one transaction in work at a time
    `LBE_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a read never moves the cursor or edits
    `LBE_ASSERT_NOW(a_read_quiet, aclk, aresetn, m_valid && (m_data.read_data != 8'd0), !m_data.applied)
    // at least one line is always in use
    `LBE_ASSERT_NOW(a_lines_nonzero, aclk, aresetn, m_valid, m_data.line_count != 7'd0)

endmodule

bind line_buffer_edit_engine lbe_checker u_lbe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
